FILE: src/kwm_pkg.sv
// shared types and codes for the k-way sorted merge
package kwm_pkg;

    // item kinds
    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_ORDER  = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_BADIDX = 3'd4
    } status_t;

    // reset value of the lists-in-use register
    localparam logic [2:0] LISTS_IN_USE_RESET = 3'd4;

    // command from the control logic to one list buffer
    typedef struct packed {
        logic              push;
        logic              pop;
        logic              clear;
        logic signed [31:0] data;
    } list_cmd_t;

    // state of one list buffer as seen by the control logic
    typedef struct packed {
        logic              nonempty;
        logic              full;
        logic              multi;
        logic signed [31:0] head;
        logic signed [31:0] last;
    } list_stat_t;

endpackage

FILE: src/kwm_list_bank.sv
// one list: circular element buffer with prefetched head and order tracking
module kwm_list_bank #(
    parameter int LIST_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  kwm_pkg::list_cmd_t cmd,
    output kwm_pkg::list_stat_t stat
);
    import kwm_pkg::*;

    localparam int PW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [PW-1:0]      head_reg, head_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic signed [31:0] last_reg, last_next;
    logic [PW:0]        wr_sum;
    logic [PW-1:0]      wr_addr;
    logic [PW-1:0]      head_inc;
    logic signed [31:0] mem [LIST_DEPTH];
    logic signed [31:0] rd_data_reg;

    // write slot is head plus fill, wrapped once
    assign wr_sum  = {1'b0, head_reg} + {1'b0, fill_reg[PW-1:0]};
    assign wr_addr = (wr_sum >= (PW+1)'(LIST_DEPTH)) ?
                     PW'(wr_sum - (PW+1)'(LIST_DEPTH)) : PW'(wr_sum);

    // head advance with wrap
    assign head_inc = (head_reg == PW'(LIST_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // pointer and count update
    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        last_next = last_reg;
        priority if (cmd.clear)
        begin
            head_next = '0;
            fill_next = '0;
            last_next = '0;
        end
        else if (cmd.push)
        begin
            fill_next = fill_reg + 1'b1;
            last_next = cmd.data;
        end
        else if (cmd.pop)
        begin
            head_next = head_inc;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
            last_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            last_reg <= last_next;
        end
    end

    // element buffer, head read at the next pointer with write bypass
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_addr] <= cmd.data;
        end
        if (cmd.push && (wr_addr == head_next))
        begin
            rd_data_reg <= cmd.data;
        end
        else
        begin
            rd_data_reg <= mem[head_next];
        end
    end

    assign stat.nonempty = (fill_reg != '0);
    assign stat.full     = (fill_reg == CW'(LIST_DEPTH));
    assign stat.multi    = (fill_reg > CW'(1));
    assign stat.head     = rd_data_reg;
    assign stat.last     = last_reg;

endmodule

FILE: src/kwm_min_tree.sv
// comparator tree that picks the smallest head, higher index on ties
module kwm_min_tree #(
    parameter int N = 4
) (
    input  logic                     cand [N],
    input  logic signed [31:0]       data [N],
    output logic                     found,
    output logic [$clog2(N)-1:0]     best_idx,
    output logic signed [31:0]       best_val
);
    import kwm_pkg::*;

    localparam int IW = $clog2(N);
    localparam int P  = 1 << IW;

    // heap layout: node k has children 2k and 2k+1, leaves from P
    logic               node_v [1:2*P-1];
    logic signed [31:0] node_d [1:2*P-1];
    logic [IW-1:0]      node_i [1:2*P-1];

    genvar g;

    // leaves, padded with empty slots
    for (g = 0; g < P; g++)
    begin : g_leaf
        if (g < N)
        begin : g_used
            assign node_v[P+g] = cand[g];
            assign node_d[P+g] = data[g];
        end
        else
        begin : g_pad
            assign node_v[P+g] = 1'b0;
            assign node_d[P+g] = '0;
        end
        assign node_i[P+g] = IW'(g);
    end

    // inner nodes: the right (higher index) side wins when not larger
    for (g = 1; g < P; g++)
    begin : g_node
        logic take_r;
        assign take_r = node_v[2*g+1] &&
                        (!node_v[2*g] || (node_d[2*g+1] <= node_d[2*g]));
        assign node_v[g] = node_v[2*g] || node_v[2*g+1];
        assign node_d[g] = take_r ? node_d[2*g+1] : node_d[2*g];
        assign node_i[g] = take_r ? node_i[2*g+1] : node_i[2*g];
    end

    assign found    = node_v[1];
    assign best_idx = node_i[1];
    assign best_val = node_d[1];

endmodule

FILE: src/k_way_sorted_merge.sv
// k-way merge of sorted lists: push, pop-smallest and clear with one result per item
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  item     | item_valid / item_stall    | kind, list_index, value
//  result   | result_valid / result_stall| out_value, out_valid, out_source,
//           |                            | out_last, status
//  config   | cfg_valid / cfg_ready      | cfg_data (lists in use)
//
// one item per cycle unless stalled; each result lands in the output register in the next cycle
// the pop path is the parallel comparator tree over the prefetched list heads
// each list keeps its next head in a registered read of its own buffer, bypassed on write
// reset clears pointers, counts and last values at once; buffer contents stay undefined
// a stalled result holds the output register and the item channel stalls with it
module k_way_sorted_merge #(
    parameter int LISTS      = 4,
    parameter int LIST_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         kind,
    input  logic [1:0]         list_index,
    input  logic signed [31:0] value,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] out_value,
    output logic               out_valid,
    output logic [1:0]         out_source,
    output logic               out_last,
    output logic [2:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_data
);
    import kwm_pkg::*;

    localparam int EW = $clog2(LISTS + 1);
    localparam int IW = $clog2(LISTS);

    logic [2:0]         lists_reg;
    logic [EW-1:0]      eff_count;
    logic               accept;
    kind_t              item_kind;

    list_cmd_t          cmd  [LISTS];
    list_stat_t         stat [LISTS];
    logic               cand [LISTS];
    logic signed [31:0] heads [LISTS];
    logic [LISTS-1:0]   nonempty_vec;

    logic               found;
    logic [IW-1:0]      best_idx;
    logic signed [31:0] best_val;
    logic               any_left;
    logic               idx_ok;
    list_stat_t         sel_stat;
    logic               push_ok;

    logic               result_valid_reg, result_valid_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_source_reg, out_source_next;
    logic               out_last_reg, out_last_next;
    status_t            status_reg, status_next;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lists_reg <= LISTS_IN_USE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            lists_reg <= cfg_data;
        end
    end

    // effective list count, clamped to one through LISTS
    always_comb
    begin
        priority if (lists_reg == 3'd0)
        begin
            eff_count = EW'(1);
        end
        else if (int'(lists_reg) > LISTS)
        begin
            eff_count = EW'(LISTS);
        end
        else
        begin
            eff_count = EW'(lists_reg);
        end
    end

    // item handshake
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;
    assign item_kind  = kind_t'(kind);

    // list buffers and their pop candidates
    for (genvar i = 0; i < LISTS; i++)
    begin : g_list
        kwm_list_bank #(
            .LIST_DEPTH (LIST_DEPTH)
        ) u_list (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd[i]),
            .stat  (stat[i])
        );
        assign cand[i]         = stat[i].nonempty && (i < int'(eff_count));
        assign heads[i]        = stat[i].head;
        assign nonempty_vec[i] = stat[i].nonempty;
    end

    kwm_min_tree #(
        .N (LISTS)
    ) u_min_tree (
        .cand     (cand),
        .data     (heads),
        .found    (found),
        .best_idx (best_idx),
        .best_val (best_val)
    );

    // push target selection and checks
    always_comb
    begin
        sel_stat = '0;
        for (int i = 0; i < LISTS; i++)
        begin
            if (int'(list_index) == i)
            begin
                sel_stat = stat[i];
            end
        end
    end

    assign idx_ok  = int'(list_index) < int'(eff_count);
    assign push_ok = idx_ok && !sel_stat.full &&
                     !(sel_stat.nonempty && (value < sel_stat.last));

    // anything left in an active list once the chosen head is gone
    always_comb
    begin
        any_left = 1'b0;
        for (int i = 0; i < LISTS; i++)
        begin
            if (cand[i] && ((int'(best_idx) != i) || stat[i].multi))
            begin
                any_left = 1'b1;
            end
        end
    end

    // per-list commands
    always_comb
    begin
        for (int i = 0; i < LISTS; i++)
        begin
            cmd[i].push  = accept && (item_kind == KIND_PUSH) && push_ok &&
                           (int'(list_index) == i);
            cmd[i].pop   = accept && (item_kind == KIND_POP) && found &&
                           (int'(best_idx) == i);
            cmd[i].clear = accept && (item_kind == KIND_CLEAR);
            cmd[i].data  = value;
        end
    end

    // result of the current item
    always_comb
    begin
        out_value_next  = '0;
        out_valid_next  = 1'b0;
        out_source_next = '0;
        out_last_next   = 1'b0;
        status_next     = ST_OK;
        unique case (item_kind)
            KIND_PUSH:
            begin
                priority if (!idx_ok)
                begin
                    status_next = ST_BADIDX;
                end
                else if (sel_stat.full)
                begin
                    status_next = ST_FULL;
                end
                else if (sel_stat.nonempty && (value < sel_stat.last))
                begin
                    status_next = ST_ORDER;
                end
                else
                begin
                    status_next = ST_OK;
                end
            end
            KIND_POP:
            begin
                if (found)
                begin
                    out_value_next  = best_val;
                    out_valid_next  = 1'b1;
                    out_source_next = 2'(best_idx);
                    out_last_next   = !any_left;
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            KIND_CLEAR,
            KIND_NOP:
            begin
                status_next = ST_OK;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        priority if (accept)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    // output payload, loaded on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg  <= out_value_next;
            out_valid_reg  <= out_valid_next;
            out_source_reg <= out_source_next;
            out_last_reg   <= out_last_next;
            status_reg     <= status_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_value    = out_value_reg;
    assign out_valid    = out_valid_reg;
    assign out_source   = out_source_reg;
    assign out_last     = out_last_reg;
    assign status       = status_reg;

    // a pop that finds an element reports it with ok status
    a_pop_reports: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item_kind == KIND_POP) && found
        |=> result_valid && out_valid && (status == ST_OK))
        else $error("pop with a candidate did not report an element");

    // a returned element never carries an error status
    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_valid |-> (status == ST_OK))
        else $error("returned element with error status");

    // last flag only marks a returned element
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_last |-> out_valid)
        else $error("last flag without returned element");

    // clear leaves every list empty
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item_kind == KIND_CLEAR) |=> (nonempty_vec == '0))
        else $error("list not empty after clear");

endmodule
